### design/sd_response_checker_assert.svh
// assertion macros for the sd response checker
`ifndef SD_RESPONSE_CHECKER_ASSERT_SVH
`define SD_RESPONSE_CHECKER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SDRC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sd_response_checker: same-cycle check failed");

// next-cycle implication, disabled during reset
`define SDRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sd_response_checker: next-cycle check failed");

`endif

### design/sdrc_pkg.sv
// types, codes and decode functions for the sd response checker
`timescale 1ns / 1ps

package sdrc_pkg;

  localparam int CmdWidth    = 6;
  localparam int StatusWidth = 32;
  localparam int ModeWidth   = 2;
  localparam int LenWidth    = 2;
  localparam int ChkWidth    = 4;

  localparam logic [ModeWidth-1:0] MODE_SD   = 2'd0;
  localparam logic [ModeWidth-1:0] MODE_SDIO = 2'd1;
  localparam logic [ModeWidth-1:0] MODE_SPI  = 2'd2;

  localparam logic [ModeWidth-1:0] OP_MODE_RESET = MODE_SD;

  localparam logic [LenWidth-1:0] LEN_NONE  = 2'd0;
  localparam logic [LenWidth-1:0] LEN_SHORT = 2'd1;
  localparam logic [LenWidth-1:0] LEN_LONG  = 2'd2;

  localparam logic [ChkWidth-1:0] CHK_OK          = 4'd0;
  localparam logic [ChkWidth-1:0] CHK_UNSUPPORTED = 4'd1;
  localparam logic [ChkWidth-1:0] CHK_CC          = 4'd2;
  localparam logic [ChkWidth-1:0] CHK_ECC         = 4'd3;
  localparam logic [ChkWidth-1:0] CHK_LOCK_UNLOCK = 4'd4;
  localparam logic [ChkWidth-1:0] CHK_LOCKED      = 4'd5;
  localparam logic [ChkWidth-1:0] CHK_WP          = 4'd6;
  localparam logic [ChkWidth-1:0] CHK_ERASE_PARAM = 4'd7;
  localparam logic [ChkWidth-1:0] CHK_ERASE_SEQ   = 4'd8;
  localparam logic [ChkWidth-1:0] CHK_ERASE_LEN   = 4'd9;
  localparam logic [ChkWidth-1:0] CHK_ADDRESS     = 4'd10;
  localparam logic [ChkWidth-1:0] CHK_ERROR       = 4'd11;
  localparam logic [ChkWidth-1:0] CHK_ILLEGAL     = 4'd12;
  localparam logic [ChkWidth-1:0] CHK_CRC         = 4'd13;
  localparam logic [ChkWidth-1:0] CHK_RANGE_AKE   = 4'd14;

  localparam logic [CmdWidth-1:0] CMD_APP_CMD         = 6'd55;
  localparam logic [CmdWidth-1:0] CMD_SD_SEND_OP_COND = 6'd41;

  typedef enum logic [2:0] {
    K_NONE,
    K_R1,
    K_R2,
    K_R4,
    K_R5,
    K_R6,
    K_R7
  } kind_t;

  // response type of each command outside the app command sequence
  function automatic kind_t kind_of_cmd(logic [CmdWidth-1:0] cmd);
    kind_t kind;
    unique case (cmd) inside
      6'd7, 6'd11, 6'd12, 6'd13, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd23, 6'd24,
      6'd25, 6'd27, 6'd28, 6'd29, 6'd30, 6'd32, 6'd33, 6'd38, 6'd40, 6'd42,
      6'd55, 6'd56: kind = K_R1;
      6'd2, 6'd9, 6'd10: kind = K_R2;
      6'd3: kind = K_R6;
      6'd5: kind = K_R4;
      6'd8: kind = K_R7;
      6'd52, 6'd53: kind = K_R5;
      default: kind = K_NONE;
    endcase
    return kind;
  endfunction

  function automatic logic [ChkWidth-1:0] check_r1(logic [ModeWidth-1:0] mode,
                                                   logic [StatusWidth-1:0] st);
    logic sd;
    logic sd_or_sdio;
    logic [ChkWidth-1:0] chk;
    sd = (mode == MODE_SD);
    sd_or_sdio = (mode == MODE_SD) || (mode == MODE_SDIO);
    if (mode == MODE_SPI) chk = CHK_UNSUPPORTED;
    else if (sd && st[20]) chk = CHK_CC;
    else if (sd && st[21]) chk = CHK_ECC;
    else if (sd && st[24]) chk = CHK_LOCK_UNLOCK;
    else if (sd && st[25]) chk = CHK_LOCKED;
    else if (sd && st[26]) chk = CHK_WP;
    else if (sd && st[27]) chk = CHK_ERASE_PARAM;
    else if (sd && st[28]) chk = CHK_ERASE_SEQ;
    else if (sd && st[29]) chk = CHK_ERASE_LEN;
    else if (sd && st[30]) chk = CHK_ADDRESS;
    else if (sd_or_sdio && st[19]) chk = CHK_ERROR;
    else if (sd_or_sdio && st[22]) chk = CHK_ILLEGAL;
    else if (sd_or_sdio && st[23]) chk = CHK_CRC;
    else if (sd_or_sdio && st[31]) chk = CHK_RANGE_AKE;
    else chk = CHK_OK;
    return chk;
  endfunction

  function automatic logic [ChkWidth-1:0] check_r6(logic [ModeWidth-1:0] mode,
                                                   logic [StatusWidth-1:0] st);
    logic sd_or_sdio;
    logic [ChkWidth-1:0] chk;
    sd_or_sdio = (mode == MODE_SD) || (mode == MODE_SDIO);
    if (mode == MODE_SPI) chk = CHK_UNSUPPORTED;
    else if ((mode == MODE_SD) && st[3]) chk = CHK_RANGE_AKE;
    else if (sd_or_sdio && st[13]) chk = CHK_ERROR;
    else if (sd_or_sdio && st[14]) chk = CHK_ILLEGAL;
    else if (sd_or_sdio && st[15]) chk = CHK_CRC;
    else chk = CHK_OK;
    return chk;
  endfunction

endpackage

### design/sd_response_checker.sv
// sd response checker: checks one card response status word per transaction
// Usage:
//   s_axis carries one transaction per command: tdata holds command_index in
//   bits 5:0 and card_status in bits 37:6. m_axis returns one transaction per
//   input: tdata holds response_length in bits 1:0 and check_result in bits 5:2.
//   The cfg channel writes op_mode (0 sd, 1 sdio, 2 spi); write it only while
//   no transaction is in flight. cfg_ready is always high.
// Latency and throughput:
//   An accepted input is held in the input register; its result is decoded and
//   loaded into the output register once that register is empty or being read,
//   and is then offered on m_axis. One transaction per cycle sustained while
//   m_axis_tready is high, set by the single decode stage between the two registers.
// Reset (rst, synchronous, active high):
//   clears both stage valid flags, the app command flag and op_mode (sd).
// Stall:
//   when m_axis_tready is low a held result stays in the output register and
//   the input register can still take one more transaction; s_axis_tready
//   drops only when both registers are full.
`timescale 1ns / 1ps
`include "sd_response_checker_assert.svh"

module sd_response_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // command_index[5:0], card_status[37:6], zero[39:38]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // response_length[1:0], check_result[5:2], zero[7:6]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data        // op_mode[1:0]
);

  logic [sdrc_pkg::ModeWidth-1:0]   op_mode;
  logic                             in_valid;
  logic [sdrc_pkg::CmdWidth-1:0]    in_cmd;
  logic [sdrc_pkg::StatusWidth-1:0] in_status;
  logic                             out_valid;
  logic [sdrc_pkg::LenWidth-1:0]    out_len;
  logic [sdrc_pkg::ChkWidth-1:0]    out_chk;
  logic                             app_pending;
  logic                             app_pending_next;
  logic                             move;
  sdrc_pkg::kind_t                  kind;
  logic [sdrc_pkg::LenWidth-1:0]    len_next;
  logic [sdrc_pkg::ChkWidth-1:0]    chk_next;

  assign cfg_ready     = 1'b1;
  assign move          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || move;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_chk, out_len};

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode <= sdrc_pkg::OP_MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      op_mode <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd    <= s_axis_tdata[5:0];
      in_status <= s_axis_tdata[37:6];
    end
  end

  // decode
  always_comb begin
    kind             = sdrc_pkg::kind_of_cmd(in_cmd);
    app_pending_next = app_pending;
    if (app_pending) begin
      len_next         = sdrc_pkg::LEN_SHORT;
      app_pending_next = 1'b0;
      if (in_cmd == sdrc_pkg::CMD_SD_SEND_OP_COND) chk_next = sdrc_pkg::CHK_OK;
      else chk_next = sdrc_pkg::check_r1(op_mode, in_status);
    end else begin
      if (kind == sdrc_pkg::K_NONE) len_next = sdrc_pkg::LEN_NONE;
      else if (kind == sdrc_pkg::K_R2) len_next = sdrc_pkg::LEN_LONG;
      else len_next = sdrc_pkg::LEN_SHORT;
      if (in_cmd == sdrc_pkg::CMD_APP_CMD) app_pending_next = 1'b1;
      case (kind)
        sdrc_pkg::K_R1: chk_next = sdrc_pkg::check_r1(op_mode, in_status);
        sdrc_pkg::K_R6: chk_next = sdrc_pkg::check_r6(op_mode, in_status);
        sdrc_pkg::K_R2, sdrc_pkg::K_R4, sdrc_pkg::K_R5,
        sdrc_pkg::K_R7: chk_next = sdrc_pkg::CHK_OK;
        default: chk_next = sdrc_pkg::CHK_UNSUPPORTED;
      endcase
    end
  end

  // output register and app command flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      app_pending <= 1'b0;
    end else begin
      if (move) begin
        out_valid   <= 1'b1;
        app_pending <= app_pending_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_len <= len_next;
      out_chk <= chk_next;
    end
  end

  `SDRC_ASSERT_NEXT(a_app_flag_clears, clk, rst, move && app_pending, !app_pending)
  `SDRC_ASSERT_NEXT(a_app_flag_sets, clk, rst,
    move && !app_pending && (in_cmd == sdrc_pkg::CMD_APP_CMD), app_pending)
  `SDRC_ASSERT_NEXT(a_move_fills_output, clk, rst, move, out_valid)
  `SDRC_ASSERT_IMP(a_stall_only_when_full, clk, rst,
    in_valid && !s_axis_tready, out_valid && !m_axis_tready)

endmodule
